@@ sv/gedd_pkg.sv @@
// Package for the gray error-diffusion dither unit: payload structs, register
// indexes, sizes (shared by front and back) and the back's arithmetic helpers.
// No dependencies.
package gedd_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int POS_W     = $clog2(MAX_LINE);
    localparam int ERR_W     = 9;
    localparam int LEN_W     = 11;
    localparam int CNT_W     = 16;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LIMIT = 2'd2;

    // Gray weights and the reciprocal of 1000 (exact for sums below 2^18).
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] WEIGHT_RED   = 18'd299;
    localparam logic [SUM_W-1:0] WEIGHT_GREEN = 18'd587;
    localparam logic [SUM_W-1:0] WEIGHT_BLUE  = 18'd114;
    localparam logic [SUM_W-1:0] GRAY_ROUND   = 18'd500;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic white;
        logic image_end;
    } result_t;

    // One classified pixel travelling from the front to the back.
    typedef struct packed {
        logic [7:0]       gray;
        logic [POS_W-1:0] pos;
        logic             first_line;
        logic             first_pix;
        logic             image_end;
    } item_t;

    // Quarter of an error, truncated toward zero.
    function automatic logic signed [ERR_W-1:0] div4_trunc(input logic signed [ERR_W-1:0] x);
        logic signed [ERR_W-1:0] adj;
        adj = x + (x[ERR_W-1] ? 9'sd3 : 9'sd0);
        return adj >>> 2;
    endfunction

    // Three eighths of an error, truncated toward zero.
    function automatic logic signed [ERR_W-1:0] mul3div8_trunc(
        input logic signed [ERR_W-1:0] x);
        logic signed [ERR_W+1:0] ext;
        logic signed [ERR_W+1:0] t;
        logic signed [ERR_W+1:0] q;
        ext = {{2{x[ERR_W-1]}}, x};
        t   = (ext <<< 1) + ext;
        t   = t + (t[ERR_W+1] ? 11'sd7 : 11'sd0);
        q   = t >>> 3;
        return q[ERR_W-1:0];
    endfunction

    // Add a signed error term to a level and clamp the result to 0..255.
    function automatic logic [7:0] add_clamp(input logic [7:0] lvl,
                                             input logic signed [ERR_W-1:0] d);
        logic signed [ERR_W:0] s;
        s = $signed({2'b00, lvl}) + $signed({d[ERR_W-1], d});
        if (s[ERR_W])
            return 8'd0;
        else if (s[ERR_W-1])
            return 8'd255;
        else
            return s[7:0];
    endfunction

endpackage

@@ sv/gedd_front.sv @@
// Front part of the dither unit: takes pixels, tracks line and image position
// and reduces each pixel to gray. Depends on gedd_pkg.
module gedd_front
    import gedd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pixel_t            pixel,
    input  logic              restart,
    input  logic [POS_W-1:0]  len_last,
    input  logic [CNT_W-1:0]  cnt_last,
    output logic              item_valid,
    input  logic              item_ready,
    output item_t             item
);

    logic [POS_W-1:0] inner_reg, inner_next;
    logic [CNT_W-1:0] outer_reg, outer_next;
    logic             valid_reg, valid_next;
    logic [SUM_W-1:0] sum_reg;
    logic [POS_W-1:0] pos_reg;
    logic             first_line_reg;
    logic             first_pix_reg;
    logic             end_reg;

    logic                           accept;
    logic                           last_pix;
    logic                           last_line;
    logic [SUM_W-1:0]               sum;
    logic [SUM_W+RECIP_W-1:0]       prod;

    assign full      = valid_reg && !item_ready;
    assign accept    = push && !full;
    assign last_pix  = (inner_reg == len_last);
    assign last_line = (outer_reg == cnt_last);

    assign sum = WEIGHT_RED * SUM_W'(pixel.red) + WEIGHT_GREEN * SUM_W'(pixel.green)
               + WEIGHT_BLUE * SUM_W'(pixel.blue) + GRAY_ROUND;

    always_comb
    begin
        inner_next = inner_reg;
        outer_next = outer_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (last_pix)
            begin
                inner_next = '0;
                outer_next = last_line ? '0 : outer_reg + 1'b1;
            end
            else
            begin
                inner_next = inner_reg + 1'b1;
            end
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        if (restart)
        begin
            inner_next = '0;
            outer_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            outer_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            inner_reg <= inner_next;
            outer_reg <= outer_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg        <= sum;
            pos_reg        <= inner_reg;
            first_line_reg <= (outer_reg == '0);
            first_pix_reg  <= (inner_reg == '0);
            end_reg        <= last_pix && last_line;
        end
    end

    // Division by 1000 as a multiplication by its scaled reciprocal.
    assign prod = SUM_W'(sum_reg) * RECIP_1000;

    assign item_valid      = valid_reg;
    assign item.gray       = prod[RECIP_SHIFT +: 8];
    assign item.pos        = pos_reg;
    assign item.first_line = first_line_reg;
    assign item.first_pix  = first_pix_reg;
    assign item.image_end  = end_reg;

endmodule

@@ sv/gedd_queue.sv @@
// Short queue of classified pixels between the front and the back.
// Depends on gedd_pkg.
module gedd_queue
    import gedd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_pop,
    output item_t rd_item
);

    item_t              slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != Q_PTR_W'(0) + (Q_PTR_W+1)'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_PTR_W+1)'(do_wr) - (Q_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

@@ sv/gedd_back.sv @@
// Back part of the dither unit: line error memory, error diffusion, the black
// or white decision and the result queue. Depends on gedd_pkg.
module gedd_back
    import gedd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  item_t              q_item,
    input  logic [LIMIT_W-1:0] black_limit,
    output logic               empty,
    input  logic               pop,
    output result_t            result
);

    // Errors of the previous line, one per position.
    logic signed [ERR_W-1:0] line_mem [MAX_LINE];

    // Stage 1: memory data arrives, diagonal term is added.
    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    logic signed [ERR_W-1:0] mem_rd_reg;
    logic                    s1_fwd_reg;
    logic signed [ERR_W-1:0] s1_fwd_val_reg;
    logic signed [ERR_W-1:0] last_above_reg;

    // Stage 2: above and previous-pixel terms, decision, write-back.
    logic                    s2_valid_reg;
    item_t                   s2_item_reg;
    logic [7:0]              s2_level_reg;
    logic signed [ERR_W-1:0] s2_above_term_reg;
    logic signed [ERR_W-1:0] prev_term_reg;

    // Result queue.
    result_t                  out_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]     out_wr_reg, out_rd_reg;
    logic [OUT_PTR_W:0]       out_count_reg, out_count_next;

    logic [OUT_PTR_W+1:0]    committed;
    logic signed [ERR_W-1:0] s1_above;
    logic signed [ERR_W-1:0] above_fin;
    logic [7:0]              level1;
    logic [7:0]              level2;
    logic [7:0]              level3;
    logic                    white;
    logic signed [ERR_W-1:0] err;
    logic                    out_rd;

    // Take an item only when the result queue has room for it and for
    // everything still in the two stages.
    assign committed = (OUT_PTR_W+2)'(out_count_reg) + (OUT_PTR_W+2)'(s1_valid_reg)
                     + (OUT_PTR_W+2)'(s2_valid_reg);
    assign q_pop = q_valid && (committed < (OUT_PTR_W+2)'(OUT_DEPTH));

    // Stage 1 logic. A write to the same position in the read cycle was
    // captured at the read; one landing now is taken from stage 2 directly.
    assign s1_above  = s1_fwd_reg ? s1_fwd_val_reg : mem_rd_reg;
    assign above_fin = (s2_valid_reg && s2_item_reg.pos == s1_item_reg.pos) ? err : s1_above;
    assign level1    = (s1_item_reg.first_line || s1_item_reg.first_pix)
                     ? s1_item_reg.gray
                     : add_clamp(s1_item_reg.gray, div4_trunc(last_above_reg));

    // Stage 2 logic.
    assign level2 = s2_item_reg.first_line ? s2_level_reg
                  : add_clamp(s2_level_reg, s2_above_term_reg);
    assign level3 = s2_item_reg.first_pix ? level2 : add_clamp(level2, prev_term_reg);
    assign white  = (level3 > black_limit);
    assign err    = white ? $signed({1'b0, level3} - 9'd255) : $signed({1'b0, level3});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_rd_reg     <= line_mem[q_item.pos];
        s1_item_reg    <= q_item;
        s1_fwd_reg     <= s2_valid_reg && (s2_item_reg.pos == q_item.pos);
        s1_fwd_val_reg <= err;
        if (s2_valid_reg)
            line_mem[s2_item_reg.pos] <= err;
    end

    always_ff @(posedge clk)
    begin
        s2_item_reg       <= s1_item_reg;
        s2_level_reg      <= level1;
        s2_above_term_reg <= mul3div8_trunc(above_fin);
        if (s1_valid_reg)
            last_above_reg <= above_fin;
        if (s2_valid_reg)
            prev_term_reg <= mul3div8_trunc(err);
    end

    // Result queue.
    assign empty  = (out_count_reg == '0);
    assign out_rd = pop && !empty;
    assign result = out_reg[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg + (OUT_PTR_W+1)'(s2_valid_reg)
                       - (OUT_PTR_W+1)'(out_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                out_wr_reg <= out_wr_reg + 1'b1;
            if (out_rd)
                out_rd_reg <= out_rd_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            out_reg[out_wr_reg].white     <= white;
            out_reg[out_wr_reg].image_end <= s2_item_reg.image_end;
        end
    end

endmodule

@@ sv/gray_error_diffusion_dither_unit.sv @@
// Top level of the gray error-diffusion dither unit: configuration registers
// and the front, queue and back parts. Depends on gedd_pkg and its submodules.
//
// Pixels enter in scan order through a queue-like port: an RGB word is taken
// at a clock edge where push is high and full is low. Each pixel produces one
// result word (white, image_end), shown on result while empty is low and
// removed at an edge where pop is high. The block sustains one pixel per
// clock while the receiver keeps up, each pixel going through the front
// register, middle queue, back stages and result queue. The recurrence via the
// previous pixel's error sits in the last back stage, which sets that rate;
// the line error memory is read two stages earlier with write-port forwarding.
// When the receiver stalls, results collect in a four-word result queue, the
// back stops taking classified pixels, the four-entry queue between front and
// back fills, and full rises once the front register is held as well.
// Reset empties all queues, sets the registers to 1024 pixels per line, 768
// lines and a black limit of 111, and starts at the first pixel of an image.
// Writing line_length or line_count restarts the image; black_limit takes
// effect at once. Users must write configuration only while idle (unenforced).
module gray_error_diffusion_dither_unit
    import gedd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pixel_t               pixel,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Line length and count are kept as last index, already clamped to the
    // range that the counters use.
    logic [POS_W-1:0]   len_last_reg, len_last_next;
    logic [CNT_W-1:0]   cnt_last_reg, cnt_last_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               restart;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    logic [LEN_W-1:0] len_in;

    assign len_in = cfg_data[LEN_W-1:0];

    always_comb
    begin
        len_last_next = len_last_reg;
        cnt_last_next = cnt_last_reg;
        limit_next    = limit_reg;
        restart       = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_LENGTH:
                begin
                    restart = 1'b1;
                    if (len_in == '0)
                        len_last_next = '0;
                    else if (len_in > LEN_W'(MAX_LINE))
                        len_last_next = POS_W'(MAX_LINE - 1);
                    else
                        len_last_next = POS_W'(len_in - 1'b1);
                end
                REG_LINE_COUNT:
                begin
                    restart       = 1'b1;
                    cnt_last_next = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
                end
                REG_BLACK_LIMIT:
                begin
                    limit_next = cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_last_reg <= POS_W'(MAX_LINE - 1);
            cnt_last_reg <= CNT_W'(767);
            limit_reg    <= LIMIT_W'(111);
        end
        else
        begin
            len_last_reg <= len_last_next;
            cnt_last_reg <= cnt_last_next;
            limit_reg    <= limit_next;
        end
    end

    gedd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .restart    (restart),
        .len_last   (len_last_reg),
        .cnt_last   (cnt_last_reg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    gedd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    gedd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .black_limit (limit_reg),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    // The back never removes a word from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("back popped the middle queue while it was empty");

    // The middle queue only drains through the back taking its last word.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(q_valid) |-> $past(q_pop))
        else $error("middle queue lost a word");

    // Backpressure at the input can only start right after a pixel was taken.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(full) |-> $past(push))
        else $error("full rose without a pixel entering the front");

endmodule
